FILE: rtl/hcbd_pkg.sv
// types, codes and character helpers shared by the chunked body decoder
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_VT = 8'h0b;
  localparam logic [7:0] CHAR_FF = 8'h0c;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] LINE_LIMIT_MIN = 8'd3;
  localparam logic [7:0] LINE_LIMIT_RST = 8'd33;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_MAX_LINE = 1'b0;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_LONG = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    PH_LINE = 6'b000001,
    PH_DATA = 6'b000010,
    PH_CR   = 6'b000100,
    PH_LF   = 6'b001000,
    PH_DONE = 6'b010000,
    PH_ERR  = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    DM_SKIP   = 3'b001,
    DM_DIGITS = 3'b010,
    DM_STOP   = 3'b100
  } digit_mode_t;

  typedef struct packed {
    logic       start_req;
    logic [7:0] in_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       chunk_last;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.hit = 1'b1;
    h.value = 4'd0;
    case (b) inside
      [8'h30:8'h39]: h.value = 4'(b - 8'h30);
      [8'h61:8'h66]: h.value = 4'(b - 8'h57);
      [8'h41:8'h46]: h.value = 4'(b - 8'h37);
      default: h.hit = 1'b0;
    endcase
    return h;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT) ||
           (b == CHAR_FF) || (b == CHAR_CR);
  endfunction

endpackage

FILE: rtl/hcbd_cfg.sv
// apb register block holding the size line length limit
`timescale 1ns / 1ps

module hcbd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hcbd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready,
  output logic [7:0]                     line_limit
);

  logic [7:0] max_line_r;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == hcbd_pkg::REG_MAX_LINE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r <= hcbd_pkg::LINE_LIMIT_RST;
    end else if (wr_en) begin
      max_line_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == hcbd_pkg::REG_MAX_LINE) ? {24'd0, max_line_r} : 32'd0;

  // values below three act as three
  assign line_limit = (max_line_r < hcbd_pkg::LINE_LIMIT_MIN) ?
                      hcbd_pkg::LINE_LIMIT_MIN : max_line_r;

endmodule

FILE: rtl/hcbd_core.sv
// framing state and per-beat decode of the chunked body
`timescale 1ns / 1ps

module hcbd_core #(
  parameter int SIZE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  hcbd_pkg::in_beat_t item,
  input  logic [7:0]         line_limit,
  output hcbd_pkg::result_t  res
);

  hcbd_pkg::phase_t      phase_r, phase_nxt;
  hcbd_pkg::digit_mode_t dmode_r, dmode_nxt;
  logic [7:0]            lcount_r, lcount_nxt;
  logic                  pcr_r, pcr_nxt;
  logic [SIZE_BITS-1:0]  acc_r, acc_nxt;
  logic [SIZE_BITS-1:0]  left_r, left_nxt;

  hcbd_pkg::phase_t      ph;
  hcbd_pkg::digit_mode_t dm;
  logic [7:0]            lc;
  logic                  pcr;
  logic [SIZE_BITS-1:0]  acc;
  logic [SIZE_BITS-1:0]  left;
  logic [7:0]            lc_inc;
  logic [7:0]            b;
  hcbd_pkg::hex_t        hx;

  always_comb begin
    b = item.in_byte;
    hx = hcbd_pkg::hex_decode(b);
    // start clears state ahead of this beat
    ph   = item.start_req ? hcbd_pkg::PH_LINE : phase_r;
    dm   = item.start_req ? hcbd_pkg::DM_SKIP : dmode_r;
    lc   = item.start_req ? 8'd0 : lcount_r;
    pcr  = item.start_req ? 1'b0 : pcr_r;
    acc  = item.start_req ? '0 : acc_r;
    left = item.start_req ? '0 : left_r;
    lc_inc = lc + 8'd1;

    phase_nxt  = ph;
    dmode_nxt  = dm;
    lcount_nxt = lc;
    pcr_nxt    = pcr;
    acc_nxt    = acc;
    left_nxt   = left;
    res        = '0;

    case (ph)
      hcbd_pkg::PH_LINE: begin
        lcount_nxt = lc_inc;
        if (b == hcbd_pkg::CHAR_LF) begin
          if (!pcr) begin
            phase_nxt = hcbd_pkg::PH_ERR;
            res.valid = 1'b1;
            res.beat.out_kind = hcbd_pkg::KIND_BAD;
          end else begin
            left_nxt   = acc;
            phase_nxt  = (acc != '0) ? hcbd_pkg::PH_DATA : hcbd_pkg::PH_CR;
            lcount_nxt = 8'd0;
            pcr_nxt    = 1'b0;
            dmode_nxt  = hcbd_pkg::DM_SKIP;
          end
        end else if (lc_inc >= line_limit) begin
          phase_nxt = hcbd_pkg::PH_ERR;
          res.valid = 1'b1;
          res.beat.out_kind = hcbd_pkg::KIND_LONG;
        end else begin
          pcr_nxt = (b == hcbd_pkg::CHAR_CR);
          if (dm != hcbd_pkg::DM_STOP) begin
            if (!hx.hit) begin
              if (!(dm == hcbd_pkg::DM_SKIP && hcbd_pkg::is_blank(b))) begin
                dmode_nxt = hcbd_pkg::DM_STOP;
              end
            end else begin
              dmode_nxt = hcbd_pkg::DM_DIGITS;
              // saturate once a further digit would overflow
              if (|acc[SIZE_BITS-1 -: 4]) begin
                acc_nxt = '1;
              end else begin
                acc_nxt = {acc[SIZE_BITS-5:0], hx.value};
              end
            end
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        left_nxt = left - SIZE_BITS'(1);
        res.valid = 1'b1;
        res.beat.out_kind = hcbd_pkg::KIND_DATA;
        res.beat.out_byte = b;
        if (left == SIZE_BITS'(1)) begin
          phase_nxt = hcbd_pkg::PH_CR;
          res.beat.chunk_last = 1'b1;
        end
      end
      hcbd_pkg::PH_CR: begin
        if (b != hcbd_pkg::CHAR_CR) begin
          phase_nxt = hcbd_pkg::PH_ERR;
          res.valid = 1'b1;
          res.beat.out_kind = hcbd_pkg::KIND_BAD;
        end else begin
          phase_nxt = hcbd_pkg::PH_LF;
        end
      end
      hcbd_pkg::PH_LF: begin
        if (b != hcbd_pkg::CHAR_LF) begin
          phase_nxt = hcbd_pkg::PH_ERR;
          res.valid = 1'b1;
          res.beat.out_kind = hcbd_pkg::KIND_BAD;
        end else if (acc == '0) begin
          phase_nxt = hcbd_pkg::PH_DONE;
          res.valid = 1'b1;
          res.beat.out_kind = hcbd_pkg::KIND_END;
        end else begin
          acc_nxt   = '0;
          phase_nxt = hcbd_pkg::PH_LINE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= hcbd_pkg::PH_LINE;
      dmode_r  <= hcbd_pkg::DM_SKIP;
      lcount_r <= 8'd0;
      pcr_r    <= 1'b0;
      acc_r    <= '0;
      left_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      dmode_r  <= dmode_nxt;
      lcount_r <= lcount_nxt;
      pcr_r    <= pcr_nxt;
      acc_r    <= acc_nxt;
      left_r   <= left_nxt;
    end
  end

  a_err_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid &&
    (res.beat.out_kind == hcbd_pkg::KIND_LONG || res.beat.out_kind == hcbd_pkg::KIND_BAD)
    |=> phase_r == hcbd_pkg::PH_ERR)
    else $error("error beat did not enter the error phase");

  a_last_to_tail: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid && res.beat.chunk_last |=> phase_r == hcbd_pkg::PH_CR)
    else $error("last payload beat did not move to the tail");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    step && !item.start_req &&
    (phase_r == hcbd_pkg::PH_DONE || phase_r == hcbd_pkg::PH_ERR) |-> !res.valid)
    else $error("result produced after end or error");

  a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.beat.out_kind != hcbd_pkg::KIND_DATA
    |-> res.beat.out_byte == 8'd0 && !res.beat.chunk_last)
    else $error("status beat carries payload bits");

endmodule

FILE: rtl/http_chunked_body_decoder.sv
// top level of the http chunked body decoder
`timescale 1ns / 1ps

// Decodes an HTTP/1.1 chunked body presented one byte per beat on the in_
// channel (in_data.start_req restarts a body before its byte). Each beat
// yields zero or one beat on the out_ channel: a payload byte (chunk_last on
// the final byte of a chunk), end of stream, size line too long or
// malformed framing. Errors and end of stream hold until start_req.
// The cfg_ APB port holds max_line_bytes at address 0; write it only when
// the block is idle. pready is always high.
// Each accepted byte passes through one input register, then the decode
// logic, then one result register.
// Throughput is one byte per cycle unless out_stall holds a result.
// A beat with no result simply leaves the result register empty.
// When out_stall is high the result holds, the next byte waits in the
// input register and in_stall rises once that register is occupied.
// Reset (rst_n low, synchronous) empties both registers, sets the limit to
// 33 and puts the decoder at the start of a size line.

module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hcbd_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hcbd_pkg::out_beat_t             out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [hcbd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  logic                in_valid_r;
  hcbd_pkg::in_beat_t  in_beat_r;
  logic                out_valid_r;
  hcbd_pkg::out_beat_t out_beat_r;
  logic                adv;
  logic                in_take;
  logic [7:0]          line_limit;
  hcbd_pkg::result_t   res;

  hcbd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .line_limit  (line_limit)
  );

  hcbd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .item       (in_beat_r),
    .line_limit (line_limit),
    .res        (res)
  );

  // decode proceeds when the result slot is free or being drained
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_beat_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_beat_r <= res.beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

endmodule
